// ----- sv/piac_pkg.sv -----
package piac_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;

  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DOT_W   = PROD_W + 2;
  localparam int CROSS_W = PROD_W + 1;
  localparam int RAD_W   = COORD_BITS - 1;
  localparam int RSQ_W   = 2 * RAD_W;

  localparam int CLO_W = (CROSS_W + 1) / 2;
  localparam int CHI_W = CROSS_W - CLO_W;
  localparam int HH_W  = 2 * CHI_W;
  localparam int HL_W  = CHI_W + CLO_W + 1;
  localparam int LL_W  = 2 * CLO_W;
  localparam int SQ_W  = 2 * CROSS_W;
  localparam int CSQ_W = SQ_W + 2;

  localparam int ALO_W = DOT_W / 2;
  localparam int AHI_W = DOT_W - ALO_W;
  localparam int RLO_W = RSQ_W / 2;
  localparam int RHI_W = RSQ_W - RLO_W;
  localparam int LPP_W = RHI_W + AHI_W;
  localparam int LIM_W = RSQ_W + DOT_W;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = COORD_BITS;
  localparam int NSTAGE    = 7;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [DOT_W-1:0]      dot_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;
  typedef logic [RAD_W-1:0]             radius_t;
  typedef logic [RSQ_W-1:0]             rsq_t;
  typedef logic signed [SQ_W-1:0]       sqs_t;
  typedef logic [CSQ_W-1:0]             csq_t;
  typedef logic [LIM_W-1:0]             lim_t;
  typedef logic [LPP_W-1:0]             lpp_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X = 3'd0,
    CFG_START_Y = 3'd1,
    CFG_START_Z = 3'd2,
    CFG_END_X   = 3'd3,
    CFG_END_Y   = 3'd4,
    CFG_END_Z   = 3'd5,
    CFG_OUTER   = 3'd6,
    CFG_INNER   = 3'd7
  } cfg_reg_t;

  localparam coord_t INNER_RADIUS_RST = coord_t'(-(64'sd1 <<< FRAC_BITS));

endpackage

// ----- sv/piac_in_if.sv -----
interface piac_in_if;
  logic                valid;
  logic                ready;
  piac_pkg::coord_t    target_x;
  piac_pkg::coord_t    target_y;
  piac_pkg::coord_t    target_z;

  modport source(output valid, output target_x, output target_y, output target_z,
                 input ready);
  modport sink(input valid, input target_x, input target_y, input target_z,
               output ready);
endinterface

// ----- sv/piac_out_if.sv -----
interface piac_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source(output valid, output inside_res, input ready);
  modport sink(input valid, input inside_res, output ready);
endinterface

// ----- sv/point_in_annular_cylinder_test_core.sv -----
// Channel   Direction  Handshake      Payload
// in_chan   sink       valid/ready    target_x, target_y, target_z (signed Q16.16)
// out_chan  source     valid/ready    inside_res
// cfg_*     write      cfg_we         cfg_index selects one of eight registers
//
// Each request passes through seven register stages; one request can be accepted every
// cycle while the pipeline is not stalled by a low out_chan.ready.
// The depth is set by the wide squared-distance and squared-limit products,
// which are built from partial products of operands at most 34 bits wide.
// Reset is synchronous; it clears the stage valid bits and loads the register defaults.
// Each stage holds while the one after it is full and stalled, so bubbles are squeezed out.
module point_in_annular_cylinder_test_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [piac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [piac_pkg::CFG_W-1:0]    cfg_wdata,
  piac_in_if.sink                       in_chan,
  piac_out_if.source                    out_chan
);
  import piac_pkg::*;

  coord_t  start_r [3];
  coord_t  end_r   [3];
  radius_t outer_r;
  coord_t  inner_r;

  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] en;

  diff_t  ax_r [3], vs_r [3], ve_r [3];
  rsq_t   ro2_r1, ri2_r1;
  logic   inner_en_r1;
  coord_t pt [3];

  prod_t  vs_a_r [3], ve_a_r [3], a_a_r [3], cpa_r [3], cpb_r [3];
  rsq_t   ro2_r2, ri2_r2;
  logic   inner_en_r2;

  dot_t   dot_s_r3, dot_e_r3, axsq_r3;
  cross_t cr_r3 [3];
  rsq_t   ro2_r3, ri2_r3;
  logic   inner_en_r3;

  logic signed [HH_W-1:0] hh_r4 [3];
  logic signed [HL_W-1:0] hl_r4 [3];
  logic [LL_W-1:0]        ll_r4 [3];
  lpp_t   lo_pp_r4 [4], li_pp_r4 [4];
  logic   ok_r4, inner_en_r4;

  logic [SQ_W-1:0] sq_r5 [3];
  lim_t   lim_o_r5, lim_i_r5;
  logic   ok_r5, inner_en_r5;

  csq_t   csq_r6;
  lim_t   lim_o_r6, lim_i_r6;
  logic   ok_r6, inner_en_r6;

  logic   inside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        start_r[i] <= '0;
        end_r[i]   <= '0;
      end
      outer_r <= '0;
      inner_r <= INNER_RADIUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_START_X: start_r[0] <= coord_t'(cfg_wdata);
        CFG_START_Y: start_r[1] <= coord_t'(cfg_wdata);
        CFG_START_Z: start_r[2] <= coord_t'(cfg_wdata);
        CFG_END_X:   end_r[0]   <= coord_t'(cfg_wdata);
        CFG_END_Y:   end_r[1]   <= coord_t'(cfg_wdata);
        CFG_END_Z:   end_r[2]   <= coord_t'(cfg_wdata);
        CFG_OUTER:   outer_r    <= cfg_wdata[RAD_W-1:0];
        CFG_INNER:   inner_r    <= coord_t'(cfg_wdata);
        default:     inner_r    <= inner_r;
      endcase
    end
  end

  always_comb begin
    en[NSTAGE-1] = !vld_r[NSTAGE-1] || out_chan.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_chan.ready       = en[0];
  assign out_chan.valid      = vld_r[NSTAGE-1];
  assign out_chan.inside_res = inside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_chan.valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign pt[0] = in_chan.target_x;
  assign pt[1] = in_chan.target_y;
  assign pt[2] = in_chan.target_z;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        ax_r[i] <= diff_t'(end_r[i]) - diff_t'(start_r[i]);
        vs_r[i] <= diff_t'(pt[i]) - diff_t'(start_r[i]);
        ve_r[i] <= diff_t'(pt[i]) - diff_t'(end_r[i]);
      end
      ro2_r1      <= outer_r * outer_r;
      ri2_r1      <= inner_r[RAD_W-1:0] * inner_r[RAD_W-1:0];
      inner_en_r1 <= !inner_r[COORD_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        vs_a_r[i] <= vs_r[i] * ax_r[i];
        ve_a_r[i] <= ve_r[i] * ax_r[i];
        a_a_r[i]  <= ax_r[i] * ax_r[i];
      end
      cpa_r[0] <= vs_r[1] * ax_r[2];
      cpb_r[0] <= vs_r[2] * ax_r[1];
      cpa_r[1] <= vs_r[2] * ax_r[0];
      cpb_r[1] <= vs_r[0] * ax_r[2];
      cpa_r[2] <= vs_r[0] * ax_r[1];
      cpb_r[2] <= vs_r[1] * ax_r[0];
      ro2_r2      <= ro2_r1;
      ri2_r2      <= ri2_r1;
      inner_en_r2 <= inner_en_r1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      dot_s_r3 <= dot_t'(vs_a_r[0]) + dot_t'(vs_a_r[1]) + dot_t'(vs_a_r[2]);
      dot_e_r3 <= dot_t'(ve_a_r[0]) + dot_t'(ve_a_r[1]) + dot_t'(ve_a_r[2]);
      axsq_r3  <= dot_t'(a_a_r[0]) + dot_t'(a_a_r[1]) + dot_t'(a_a_r[2]);
      for (int i = 0; i < 3; i++) begin
        cr_r3[i] <= cross_t'(cpa_r[i]) - cross_t'(cpb_r[i]);
      end
      ro2_r3      <= ro2_r2;
      ri2_r3      <= ri2_r2;
      inner_en_r3 <= inner_en_r2;
    end
  end

  logic signed [CHI_W-1:0] c_hi [3];
  logic [CLO_W-1:0]        c_lo [3];
  logic [AHI_W-1:0]        a_hi;
  logic [ALO_W-1:0]        a_lo;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_hi[i] = cr_r3[i][CROSS_W-1:CLO_W];
      c_lo[i] = cr_r3[i][CLO_W-1:0];
    end
    a_hi = axsq_r3[DOT_W-1:ALO_W];
    a_lo = axsq_r3[ALO_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        hh_r4[i] <= c_hi[i] * c_hi[i];
        hl_r4[i] <= c_hi[i] * $signed({1'b0, c_lo[i]});
        ll_r4[i] <= c_lo[i] * c_lo[i];
      end
      lo_pp_r4[0] <= ro2_r3[RSQ_W-1:RLO_W] * a_hi;
      lo_pp_r4[1] <= ro2_r3[RSQ_W-1:RLO_W] * a_lo;
      lo_pp_r4[2] <= ro2_r3[RLO_W-1:0] * a_hi;
      lo_pp_r4[3] <= ro2_r3[RLO_W-1:0] * a_lo;
      li_pp_r4[0] <= ri2_r3[RSQ_W-1:RLO_W] * a_hi;
      li_pp_r4[1] <= ri2_r3[RSQ_W-1:RLO_W] * a_lo;
      li_pp_r4[2] <= ri2_r3[RLO_W-1:0] * a_hi;
      li_pp_r4[3] <= ri2_r3[RLO_W-1:0] * a_lo;
      ok_r4 <= (axsq_r3 != '0) && !dot_s_r3[DOT_W-1] && (dot_s_r3 != '0)
               && dot_e_r3[DOT_W-1];
      inner_en_r4 <= inner_en_r3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        sq_r5[i] <= (sqs_t'(hh_r4[i]) <<< (2 * CLO_W))
                  + (sqs_t'(hl_r4[i]) <<< (CLO_W + 1))
                  + sqs_t'(ll_r4[i]);
      end
      lim_o_r5 <= (lim_t'(lo_pp_r4[0]) << (RLO_W + ALO_W))
                + (lim_t'(lo_pp_r4[1]) << RLO_W)
                + (lim_t'(lo_pp_r4[2]) << ALO_W)
                + lim_t'(lo_pp_r4[3]);
      lim_i_r5 <= (lim_t'(li_pp_r4[0]) << (RLO_W + ALO_W))
                + (lim_t'(li_pp_r4[1]) << RLO_W)
                + (lim_t'(li_pp_r4[2]) << ALO_W)
                + lim_t'(li_pp_r4[3]);
      ok_r5       <= ok_r4;
      inner_en_r5 <= inner_en_r4;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      csq_r6      <= csq_t'(sq_r5[0]) + csq_t'(sq_r5[1]) + csq_t'(sq_r5[2]);
      lim_o_r6    <= lim_o_r5;
      lim_i_r6    <= lim_i_r5;
      ok_r6       <= ok_r5;
      inner_en_r6 <= inner_en_r5;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      inside_r <= ok_r6 && (csq_r6 < csq_t'(lim_o_r6))
                  && (!inner_en_r6 || (csq_r6 >= csq_t'(lim_i_r6)));
    end
  end

endmodule
